// ===== rtl/core/dqt_pkg.sv =====
// ----------------------------------------------------------------------------
// dqt_pkg
// Shared types, codes and the zigzag-to-natural table for the DQT parser.
// ----------------------------------------------------------------------------
package dqt_pkg;

    localparam int TBL_ENTRIES  = 64;
    localparam int NARROW_BYTES = 64;
    localparam int WIDE_BYTES   = 64 * 2;
    localparam int FIFO_DEPTH   = 3;
    localparam logic [3:0] NIBBLE_MASK = 4'h0f;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_BAD_PREC = 3'd3;
    localparam logic [2:0] ST_BAD_TGT  = 3'd4;
    localparam logic [2:0] ST_INSUFF   = 3'd5;
    localparam logic [2:0] ST_RAN_OUT  = 3'd6;
    localparam logic [2:0] ST_CORRUPT  = 3'd7;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_LEN_LO   = 6'b000010,
        PH_HEADER   = 6'b000100,
        PH_ENTRY    = 6'b001000,
        PH_ENTRY_LO = 6'b010000,
        PH_HALT     = 6'b100000
    } phase_t;

    // Per-request outcome from the parser, before the table read returns.
    typedef struct packed {
        logic [2:0] status;
        logic       committed;
        logic [1:0] committed_table;
        logic       read_present;
    } ctl_result_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        committed;
        logic [1:0]  committed_table;
        logic [15:0] read_value;
        logic        read_present;
    } out_item_t;

    localparam logic [5:0] ZZ_TO_NAT [TBL_ENTRIES] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

endpackage

// ===== rtl/core/dqt_req_if.sv =====
// ----------------------------------------------------------------------------
// dqt_req_if
// Request channel: valid/ready plus command payload.
// ----------------------------------------------------------------------------
interface dqt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       segment_start;
    logic [1:0] read_table;
    logic [5:0] read_position;

    modport source (output valid, command, data_byte, segment_start, read_table,
                    read_position, input ready);
    modport sink   (input valid, command, data_byte, segment_start, read_table,
                    read_position, output ready);
endinterface

// ===== rtl/core/dqt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dqt_rsp_if
// Result channel: valid/ready plus status and readback payload.
// ----------------------------------------------------------------------------
interface dqt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        committed;
    logic [1:0]  committed_table;
    logic [15:0] read_value;
    logic        read_present;

    modport source (output valid, status, committed, committed_table, read_value,
                    read_present, input ready);
    modport sink   (input valid, status, committed, committed_table, read_value,
                    read_present, output ready);
endinterface

// ===== rtl/core/dqt_segment_parser_core.sv =====
// ----------------------------------------------------------------------------
// dqt_segment_parser_core
// JPEG DQT segment parser with quantization table store and readback.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one command per handshake: a segment byte (segment_start
//   marks the first length byte), end of stream, or a table-entry read.
//   result returns exactly one item per request, in request order: status,
//   commit flag and table number, and readback value/present.
// Path: an accepted request's outcome is registered in the stage aligned with
//   the table memory read, then in the result queue, before result shows it.
// Throughput: one request per cycle while the result queue has room. Each byte
//   does constant work: one parser step and at most one write into the table memory.
// Tables: entries are staged directly into a spare memory slot; completing a
//   table swaps that slot into the slot map, so no copy pass is needed.
//   Memory holds (NUM_TABLES+1)*64 16-bit entries.
// Reset: parser goes idle, no table is present, slot map returns to identity.
//   The memory itself is not cleared; absent tables read back as zero.
// Stall: a three-entry result queue keeps accepting while results wait; ready
//   drops once the queue plus the read in flight would fill it.
// ----------------------------------------------------------------------------
module dqt_segment_parser_core
    import dqt_pkg::*;
#(
    parameter int NUM_TABLES = 4
)(
    input  logic      clk,
    input  logic      rst_n,
    dqt_req_if.sink   request,
    dqt_rsp_if.source result
);
    // Slot index covers the NUM_TABLES live slots plus one spare.
    localparam int SW = (NUM_TABLES + 1 > 1) ? $clog2(NUM_TABLES + 1) : 1;

    logic          accept;
    ctl_result_t   ctl_res;
    logic          mem_we;
    logic [SW+5:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [SW+5:0] mem_raddr;
    logic [15:0]   mem_rdata;

    logic          stage_valid_reg;
    ctl_result_t   stage_res_reg;

    out_item_t     push_item;
    out_item_t     head;
    logic          not_empty;
    logic [1:0]    fifo_count;
    logic          pop;

    assign accept = request.valid && request.ready;

    dqt_parse_ctl #(
        .NUM_TABLES (NUM_TABLES),
        .SW         (SW)
    ) u_ctl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (request.command),
        .data_byte     (request.data_byte),
        .segment_start (request.segment_start),
        .read_table    (request.read_table),
        .read_position (request.read_position),
        .res           (ctl_res),
        .we            (mem_we),
        .waddr         (mem_waddr),
        .wdata         (mem_wdata),
        .re            (mem_re),
        .raddr         (mem_raddr)
    );

    dqt_table_mem #(
        .NUM_TABLES (NUM_TABLES),
        .SW         (SW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Stage aligned with the memory read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_res_reg <= ctl_res;
        end
    end

    always_comb
    begin
        push_item.status          = stage_res_reg.status;
        push_item.committed       = stage_res_reg.committed;
        push_item.committed_table = stage_res_reg.committed_table;
        push_item.read_present    = stage_res_reg.read_present;
        push_item.read_value      = stage_res_reg.read_present ? mem_rdata : 16'h0000;
    end

    assign pop = result.valid && result.ready;

    dqt_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stage_valid_reg),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    // Count the result in flight so the queue never overflows.
    assign request.ready = ({1'b0, fifo_count} + {2'b00, stage_valid_reg})
                           < 3'(FIFO_DEPTH);

    assign result.valid           = not_empty;
    assign result.status          = head.status;
    assign result.committed       = head.committed;
    assign result.committed_table = head.committed_table;
    assign result.read_value      = head.read_value;
    assign result.read_present    = head.read_present;
endmodule

// ===== rtl/core/dqt_table_mem.sv =====
// ----------------------------------------------------------------------------
// dqt_table_mem
// Table store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dqt_table_mem
    import dqt_pkg::*;
#(
    parameter int NUM_TABLES = 4,
    parameter int SW         = 3
)(
    input  logic              clk,
    input  logic              we,
    input  logic [SW+5:0]     waddr,
    input  logic [15:0]       wdata,
    input  logic              re,
    input  logic [SW+5:0]     raddr,
    output logic [15:0]       rdata
);
    localparam int DEPTH = (NUM_TABLES + 1) * TBL_ENTRIES;

    logic [15:0] mem_array [DEPTH];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read data holds until the next read request.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/dqt_parse_ctl.sv =====
// ----------------------------------------------------------------------------
// dqt_parse_ctl
// Segment parser state machine, slot map and table-present bits.
// ----------------------------------------------------------------------------
module dqt_parse_ctl
    import dqt_pkg::*;
#(
    parameter int NUM_TABLES = 4,
    parameter int SW         = 3
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [1:0]        command,
    input  logic [7:0]        data_byte,
    input  logic              segment_start,
    input  logic [1:0]        read_table,
    input  logic [5:0]        read_position,
    output ctl_result_t       res,
    output logic              we,
    output logic [SW+5:0]     waddr,
    output logic [15:0]       wdata,
    output logic              re,
    output logic [SW+5:0]     raddr
);
    phase_t                phase_reg, phase_next;
    logic [15:0]           bytes_left_reg, bytes_left_next;
    logic [5:0]            count_reg, count_next;
    logic [1:0]            target_reg, target_next;
    logic                  wide_reg, wide_next;
    logic [7:0]            held_reg, held_next;
    logic [NUM_TABLES-1:0] present_reg, present_next;
    logic [SW-1:0]         map_reg [NUM_TABLES];
    logic [SW-1:0]         map_next [NUM_TABLES];
    logic [SW-1:0]         free_reg, free_next;

    logic        take;
    logic [15:0] take_value;
    logic        blk_check;
    logic [15:0] blk_value;
    logic [15:0] bl_dec;
    logic [15:0] len;
    logic [3:0]  prec;
    logic [3:0]  tgt;
    logic [15:0] need;
    logic        rd_hit;
    logic [SW-1:0] rd_slot;
    logic [SW-1:0] commit_slot;

    assign bl_dec = bytes_left_reg - 16'd1;
    assign len    = {held_reg, data_byte};
    assign prec   = data_byte[7:4];
    assign tgt    = data_byte[3:0] & NIBBLE_MASK;
    assign need   = prec[0] ? 16'(WIDE_BYTES) : 16'(NARROW_BYTES);

    // Slot of the table being read and of the table being replaced.
    always_comb
    begin
        rd_hit      = 1'b0;
        rd_slot     = '0;
        commit_slot = '0;
        for (int i = 0; i < NUM_TABLES; i++)
        begin
            if (read_table == 2'(i))
            begin
                rd_hit  = present_reg[i];
                rd_slot = map_reg[i];
            end
            if (target_reg == 2'(i))
            begin
                commit_slot = map_reg[i];
            end
        end
    end

    assign re    = accept && (command == CMD_READ) && rd_hit;
    assign raddr = {rd_slot, read_position};
    // Staging goes straight into the spare slot.
    assign waddr = {free_reg, ZZ_TO_NAT[count_reg]};

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        count_next      = count_reg;
        target_next     = target_reg;
        wide_next       = wide_reg;
        held_next       = held_reg;
        present_next    = present_reg;
        free_next       = free_reg;
        for (int i = 0; i < NUM_TABLES; i++)
        begin
            map_next[i] = map_reg[i];
        end
        res        = '0;
        we         = 1'b0;
        take       = 1'b0;
        take_value = {8'h00, data_byte};
        blk_check  = 1'b0;
        blk_value  = bl_dec;

        if (accept)
        begin
            case (command)
                CMD_BYTE:
                begin
                    if (segment_start)
                    begin
                        held_next  = data_byte;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_LEN_LO:
                            begin
                                if (len < 16'd2)
                                begin
                                    res.status = ST_SHORT;
                                    phase_next = PH_HALT;
                                end
                                else
                                begin
                                    bytes_left_next = len - 16'd2;
                                    blk_check       = 1'b1;
                                    blk_value       = len - 16'd2;
                                end
                            end
                            PH_HEADER:
                            begin
                                phase_next = PH_HALT;
                                if (prec > 4'd1)
                                begin
                                    res.status = ST_BAD_PREC;
                                end
                                else if (tgt >= 4'(NUM_TABLES))
                                begin
                                    res.status = ST_BAD_TGT;
                                end
                                else
                                begin
                                    bytes_left_next = bl_dec;
                                    if (bl_dec < need)
                                    begin
                                        res.status = ST_INSUFF;
                                    end
                                    else
                                    begin
                                        target_next = tgt[1:0];
                                        wide_next   = prec[0];
                                        count_next  = '0;
                                        phase_next  = PH_ENTRY;
                                    end
                                end
                            end
                            PH_ENTRY:
                            begin
                                bytes_left_next = bl_dec;
                                if (wide_reg)
                                begin
                                    held_next  = data_byte;
                                    phase_next = PH_ENTRY_LO;
                                end
                                else
                                begin
                                    take = 1'b1;
                                end
                            end
                            PH_ENTRY_LO:
                            begin
                                bytes_left_next = bl_dec;
                                take            = 1'b1;
                                take_value      = {held_reg, data_byte};
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                CMD_END:
                begin
                    case (phase_reg)
                        PH_LEN_LO:
                        begin
                            res.status = ST_SHORT;
                            phase_next = PH_HALT;
                        end
                        PH_HEADER, PH_ENTRY, PH_ENTRY_LO:
                        begin
                            res.status = ST_RAN_OUT;
                            phase_next = PH_HALT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_READ:
                begin
                    res.read_present = rd_hit;
                end
                default:
                begin
                end
            endcase
        end

        if (take)
        begin
            we         = 1'b1;
            count_next = count_reg + 6'd1;
            if (count_reg != 6'(TBL_ENTRIES - 1))
            begin
                phase_next = PH_ENTRY;
            end
            else
            begin
                // Commit: staged slot becomes the table, old slot is the spare.
                for (int i = 0; i < NUM_TABLES; i++)
                begin
                    if (target_reg == 2'(i))
                    begin
                        map_next[i]     = free_reg;
                        present_next[i] = 1'b1;
                    end
                end
                free_next           = commit_slot;
                res.committed       = 1'b1;
                res.committed_table = target_reg;
                blk_check           = 1'b1;
                blk_value           = bl_dec;
            end
        end

        if (blk_check)
        begin
            if (blk_value > 16'd2)
            begin
                phase_next = PH_HEADER;
            end
            else
            begin
                phase_next = PH_HALT;
                res.status = (blk_value == 16'd0) ? ST_DONE : ST_CORRUPT;
            end
        end
    end

    assign wdata = take_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bytes_left_reg <= '0;
            count_reg      <= '0;
            target_reg     <= '0;
            wide_reg       <= 1'b0;
            held_reg       <= '0;
            present_reg    <= '0;
            free_reg       <= SW'(NUM_TABLES);
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                map_reg[i] <= SW'(i);
            end
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            count_reg      <= count_next;
            target_reg     <= target_next;
            wide_reg       <= wide_next;
            held_reg       <= held_next;
            present_reg    <= present_next;
            free_reg       <= free_next;
            for (int i = 0; i < NUM_TABLES; i++)
            begin
                map_reg[i] <= map_next[i];
            end
        end
    end
endmodule

// ===== rtl/core/dqt_result_fifo.sv =====
// ----------------------------------------------------------------------------
// dqt_result_fifo
// Three-entry result queue that decouples the parser from the receiver.
// ----------------------------------------------------------------------------
module dqt_result_fifo
    import dqt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    input  logic      pop,
    output out_item_t head,
    output logic      not_empty,
    output logic [1:0] count
);
    out_item_t  slot_array [FIFO_DEPTH];
    logic [1:0] wr_ptr_reg, rd_ptr_reg, count_reg;

    function automatic logic [1:0] bump(input logic [1:0] p);
        return (p == 2'(FIFO_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_array[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign head      = slot_array[rd_ptr_reg];
    assign not_empty = (count_reg != 2'd0);
    assign count     = count_reg;
endmodule

// ===== rtl/core/dqt_checker.sv =====
// ----------------------------------------------------------------------------
// dqt_checker
// Port-level checks on the result channel of the DQT parser.
// ----------------------------------------------------------------------------
module dqt_checker
    import dqt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic        committed,
    input logic [1:0]  committed_table,
    input logic [15:0] read_value,
    input logic        read_present
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
                                    && $stable(read_value))
        else $error("result dropped or changed while stalled");

    a_commit_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && committed |-> status == ST_OK || status == ST_DONE
                                   || status == ST_CORRUPT)
        else $error("commit reported with error status");

    a_no_commit_table: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !committed |-> committed_table == 2'd0)
        else $error("table number without commit");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_present |-> read_value == 16'h0000)
        else $error("read value without present table");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_present |-> status == ST_OK && !committed)
        else $error("read result mixed with parse result");
endmodule

bind dqt_segment_parser_core dqt_checker u_dqt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .status          (result.status),
    .committed       (result.committed),
    .committed_table (result.committed_table),
    .read_value      (result.read_value),
    .read_present    (result.read_present)
);
